// ----- src/brf_pkg.sv -----
// Shared types, constants and helper functions of the Brent root finder.
package brf_pkg;

  // Number format: only the reset value of the tolerance depends on it.
  localparam int unsigned FracBits = 16;

  // Field widths.
  localparam int unsigned ValW   = 32;
  localparam int unsigned TolW   = 31;
  localparam int unsigned IterW  = 8;
  localparam int unsigned StepW  = 16;
  localparam int unsigned KindW  = 2;
  localparam int unsigned CfgIdxW = 2;

  // Configuration reset values.
  localparam logic [TolW-1:0]  TolReset    = TolW'((1 << FracBits) / 1000 + 1);
  localparam logic [IterW-1:0] LimitReset  = 8'd100;
  localparam logic [StepW-1:0] MinStepReset = 16'd1;
  localparam logic [StepW-1:0] MarginReset  = 16'd0;

  // Divider geometry: quotients are saturated to 2^40, so 41 bits suffice.
  localparam int unsigned NumW   = 96;
  localparam int unsigned DenW   = 64;
  localparam int unsigned QuotW  = 41;
  localparam logic [QuotW-1:0] QCap = QuotW'(1) << (QuotW - 1);
  localparam logic [1:0] LastTerm = 2'd2;

  // Input command codes.
  localparam logic CmdStart    = 1'b0;
  localparam logic CmdResponse = 1'b1;

  // Result kinds.
  localparam logic [KindW-1:0] KindEval  = 2'd0;
  localparam logic [KindW-1:0] KindRoot  = 2'd1;
  localparam logic [KindW-1:0] KindNoBkt = 2'd2;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    CFG_TOLERANCE = 2'd0,
    CFG_ITER_LIMIT = 2'd1,
    CFG_MIN_STEP = 2'd2,
    CFG_EQUAL_MARGIN = 2'd3
  } cfg_idx_e;

  // Datapath operations issued by the controller.
  typedef enum logic [4:0] {
    OP_NONE     = 5'd0,
    OP_START    = 5'd1,
    OP_LOAD_FA  = 5'd2,
    OP_LOAD_FB  = 5'd3,
    OP_LOAD_FC  = 5'd4,
    OP_PLAN     = 5'd5,
    OP_MUL_DEN  = 5'd6,
    OP_MUL_FF   = 5'd7,
    OP_MUL_XLO  = 5'd8,
    OP_MUL_XHI  = 5'd9,
    OP_NUM_SUM  = 5'd10,
    OP_MUL_SEC  = 5'd11,
    OP_DIV_GO   = 5'd12,
    OP_ACC      = 5'd13,
    OP_ACC_SEC  = 5'd14,
    OP_CLAMP    = 5'd15,
    OP_CHOOSE   = 5'd16,
    OP_LOAD_FS  = 5'd17,
    OP_FINISH   = 5'd18
  } op_e;

  typedef struct packed {
    op_e        op;
    logic [1:0] term;
  } dp_cmd_t;

  typedef struct packed {
    logic bracketed;
    logic use_iqi;
    logic use_sec;
    logic div_done;
    logic cont;
  } dp_status_t;

  // Magnitude of a 32-bit signed value, as 32 unsigned bits.
  function automatic logic [31:0] mag32(input logic [31:0] v);
    mag32 = v[31] ? (~v + 32'd1) : v;
  endfunction

  // Magnitude of a difference of two 32-bit values; it never exceeds 2^32-1.
  function automatic logic [31:0] mag33(input logic [32:0] v);
    logic [32:0] n;
    n = v[32] ? (~v + 33'd1) : v;
    mag33 = n[31:0];
  endfunction

  // Exact 33-bit difference x - y of two 32-bit signed values.
  function automatic logic [32:0] sdiff(input logic [31:0] x, input logic [31:0] y);
    sdiff = {x[31], x} - {y[31], y};
  endfunction

endpackage

// ----- src/brf_divider.sv -----
// Restoring divider, one quotient bit per cycle, quotient saturated to 2^40.
module brf_divider (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [brf_pkg::NumW-1:0] dividend_i,
  input  logic [brf_pkg::DenW-1:0] divisor_i,
  output logic                     done_o,
  output logic [brf_pkg::QuotW-1:0] quot_o
);
  import brf_pkg::*;

  logic             run_q, done_q, ovf_q;
  logic [5:0]       cnt_q;
  logic [DenW-1:0]  rem_q, dsr_q;
  logic [QuotW-1:0] low_q, quot_q;
  logic [DenW:0]    trial;
  logic             fits;

  // One trial subtraction per cycle.
  assign trial = {rem_q, low_q[QuotW-1]};
  assign fits  = trial >= {1'b0, dsr_q};

  // Only the low 41 quotient bits are formed; a larger quotient saturates.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      ovf_q  <= 1'b0;
      cnt_q  <= '0;
      rem_q  <= '0;
      dsr_q  <= '0;
      low_q  <= '0;
      quot_q <= '0;
    end else if (start_i) begin
      ovf_q  <= {9'd0, dividend_i[NumW-1:QuotW]} >= divisor_i;
      rem_q  <= {9'd0, dividend_i[NumW-1:QuotW]};
      dsr_q  <= divisor_i;
      low_q  <= dividend_i[QuotW-1:0];
      quot_q <= '0;
      cnt_q  <= 6'(QuotW);
      run_q  <= 1'b1;
      done_q <= 1'b0;
    end else if (run_q) begin
      rem_q  <= fits ? DenW'(trial - {1'b0, dsr_q}) : trial[DenW-1:0];
      low_q  <= {low_q[QuotW-2:0], 1'b0};
      quot_q <= {quot_q[QuotW-2:0], fits};
      cnt_q  <= cnt_q - 6'd1;
      if (cnt_q == 6'd1) begin
        run_q  <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  assign done_o = done_q;
  assign quot_o = (ovf_q || (quot_q > QCap)) ? QCap : quot_q;

endmodule

// ----- src/brf_datapath.sv -----
// Datapath of the Brent root finder: bracket state, multiplier, divider, checks.
module brf_datapath #(
  parameter int unsigned FracBits = brf_pkg::FracBits
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  brf_pkg::dp_cmd_t             cmd_i,
  output brf_pkg::dp_status_t          status_o,
  input  logic                         cfg_we_i,
  input  logic [brf_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [brf_pkg::TolW-1:0]     cfg_data_i,
  input  logic signed [31:0]           bracket_low_i,
  input  logic signed [31:0]           bracket_high_i,
  input  logic signed [31:0]           func_value_i,
  output logic                         result_valid_o,
  output logic [brf_pkg::KindW-1:0]    kind_o,
  output logic signed [31:0]           point_o,
  output logic [brf_pkg::IterW-1:0]    iterations_o
);
  import brf_pkg::*;

  // Reset value of the tolerance for the chosen number format.
  localparam logic [TolW-1:0] TolRst = TolW'((1 << FracBits) / 1000 + 1);

  // Configuration registers.
  logic [TolW-1:0]  tol_q;
  logic [IterW-1:0] limit_q;
  logic [StepW-1:0] min_step_q, margin_q;

  // Search state.
  logic [31:0] pt_a_q, pt_b_q, pt_c_q, pt_d_q, pt_s_q;
  logic [31:0] val_a_q, val_b_q, val_c_q, val_s_q;
  logic        bisect_q, force_bis_q, neg_q;
  logic [IterW-1:0] iter_q;

  // Arithmetic registers.
  logic [DenW-1:0]   den_q, prod_q, part_q, part_hi_q;
  logic [NumW-1:0]   numer_q;
  logic signed [42:0] acc_q;
  logic [31:0]       s_q;

  // Result registers.
  logic             res_valid_q;
  logic [KindW-1:0] kind_q;
  logic [31:0]      point_q;
  logic [IterW-1:0] iters_q;

  // Term operands, multiplier and divider.
  logic [31:0] t_x, t_f1, t_f2;
  logic [32:0] t_g1, t_g2;
  logic        t_neg;
  logic [32:0] sec_dx, sec_df;
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;
  logic              div_done;
  logic [QuotW-1:0]  quot;
  logic signed [42:0] sq_ext;

  // Checks and updates.
  logic        near_ac, near_bc, use_iqi, use_sec, bkt_fb;
  logic        swap_fb;
  logic [31:0] clamp_s;
  logic [34:0] sum3, lo_adj;
  logic signed [32:0] lo_v, hi_v, lo_s, hi_s, s_v;
  logic [31:0] step, sb_mag;
  logic [32:0] sum2, mid_adj;
  logic [31:0] mid;
  logic        bis;
  logic [31:0] s_new;
  logic        opp_s, swap_fs;
  logic [31:0] na, nva, nb, nvb;
  logic [31:0] mb, ms, mx;
  logic        cont;

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q      <= TolRst;
      limit_q    <= LimitReset;
      min_step_q <= MinStepReset;
      margin_q   <= MarginReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_TOLERANCE:    tol_q      <= cfg_data_i;
        CFG_ITER_LIMIT:   limit_q    <= cfg_data_i[IterW-1:0];
        CFG_MIN_STEP:     min_step_q <= cfg_data_i[StepW-1:0];
        CFG_EQUAL_MARGIN: margin_q   <= cfg_data_i[StepW-1:0];
        default: ;
      endcase
    end
  end

  // Method choice for the next point.
  assign near_ac = mag33(sdiff(val_a_q, val_c_q)) <= {16'd0, margin_q};
  assign near_bc = mag33(sdiff(val_b_q, val_c_q)) <= {16'd0, margin_q};
  assign use_sec = val_a_q != val_b_q;
  assign use_iqi = !near_ac && !near_bc && use_sec && (val_a_q != val_c_q) &&
                   (val_b_q != val_c_q);

  // Differences used by the secant step.
  assign sec_dx = sdiff(pt_b_q, pt_a_q);
  assign sec_df = sdiff(val_b_q, val_a_q);

  // Operands of one inverse quadratic interpolation term.
  always_comb begin
    case (cmd_i.term)
      2'd0: begin
        t_x = pt_a_q; t_f1 = val_b_q; t_f2 = val_c_q;
        t_g1 = sdiff(val_a_q, val_b_q); t_g2 = sdiff(val_a_q, val_c_q);
      end
      2'd1: begin
        t_x = pt_b_q; t_f1 = val_a_q; t_f2 = val_c_q;
        t_g1 = sdiff(val_b_q, val_a_q); t_g2 = sdiff(val_b_q, val_c_q);
      end
      default: begin
        t_x = pt_c_q; t_f1 = val_a_q; t_f2 = val_b_q;
        t_g1 = sdiff(val_c_q, val_a_q); t_g2 = sdiff(val_c_q, val_b_q);
      end
    endcase
    t_neg = t_x[31] ^ t_f1[31] ^ t_f2[31] ^ t_g1[32] ^ t_g2[32];
  end

  // Shared 32 by 32 multiplier.
  always_comb begin
    case (cmd_i.op)
      OP_MUL_DEN: begin mul_a = mag33(t_g1);      mul_b = mag33(t_g2);  end
      OP_MUL_FF:  begin mul_a = mag32(t_f1);      mul_b = mag32(t_f2);  end
      OP_MUL_XLO: begin mul_a = prod_q[31:0];     mul_b = mag32(t_x);   end
      OP_MUL_XHI: begin mul_a = prod_q[63:32];    mul_b = mag32(t_x);   end
      OP_MUL_SEC: begin
        mul_a = mag32(val_b_q);
        mul_b = mag33(sec_dx);
      end
      default:    begin mul_a = '0;               mul_b = '0;           end
    endcase
  end
  assign mul_p = mul_a * mul_b;

  brf_divider u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.op == OP_DIV_GO),
    .dividend_i (numer_q),
    .divisor_i  (den_q),
    .done_o     (div_done),
    .quot_o     (quot)
  );

  assign sq_ext = neg_q ? -$signed({2'b00, quot}) : $signed({2'b00, quot});

  // Saturate the accumulated point to the 32-bit range.
  assign clamp_s = (acc_q[42:31] != {12{acc_q[42]}}) ?
                   (acc_q[42] ? 32'h8000_0000 : 32'h7FFF_FFFF) : acc_q[31:0];

  // Acceptance window and bisection fallback.
  always_comb begin
    sum3   = ({{3{pt_a_q[31]}}, pt_a_q} << 1) + {{3{pt_a_q[31]}}, pt_a_q} +
             {{3{pt_b_q[31]}}, pt_b_q};
    lo_adj = sum3 + (sum3[34] ? 35'd3 : 35'd0);
    lo_v   = $signed(lo_adj[34:2]);
    hi_v   = $signed({pt_b_q[31], pt_b_q});
    if (lo_v > hi_v) begin
      lo_s = hi_v; hi_s = lo_v;
    end else begin
      lo_s = lo_v; hi_s = hi_v;
    end
    s_v    = $signed({s_q[31], s_q});
    step   = bisect_q ? mag33(sdiff(pt_b_q, pt_c_q)) : mag33(sdiff(pt_c_q, pt_d_q));
    sb_mag = mag33(sdiff(s_q, pt_b_q));
    sum2   = {pt_a_q[31], pt_a_q} + {pt_b_q[31], pt_b_q};
    mid_adj = sum2 + (sum2[32] ? 33'd1 : 33'd0);
    mid    = mid_adj[32:1];
    bis    = force_bis_q || (s_v < lo_s) || (s_v > hi_s) ||
             ({sb_mag, 1'b0} >= {1'b0, step}) || (step < {16'd0, min_step_q});
    s_new  = bis ? mid : s_q;
  end

  // Bracket check on the value at b, with the swap that keeps b the better end.
  assign bkt_fb  = (val_a_q[31] && !func_value_i[31] && (func_value_i != '0)) ||
                   (!val_a_q[31] && (val_a_q != '0) && func_value_i[31]);
  assign swap_fb = mag32(val_a_q) < mag32(func_value_i);

  // Bracket update with the value at s.
  always_comb begin
    opp_s = (val_a_q[31] && !func_value_i[31] && (func_value_i != '0)) ||
            (!val_a_q[31] && (val_a_q != '0) && func_value_i[31]);
    na  = opp_s ? pt_a_q  : pt_s_q;
    nva = opp_s ? val_a_q : func_value_i;
    nb  = opp_s ? pt_s_q  : pt_b_q;
    nvb = opp_s ? func_value_i : val_b_q;
    swap_fs = mag32(nva) < mag32(nvb);
  end

  // Stopping test.
  assign mb   = mag32(val_b_q);
  assign ms   = mag32(val_s_q);
  assign mx   = (mb > ms) ? mb : ms;
  assign cont = (mx > {1'b0, tol_q}) && (iter_q < limit_q);

  // State and arithmetic registers, driven by the current operation.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pt_a_q <= '0; pt_b_q <= '0; pt_c_q <= '0; pt_d_q <= '0; pt_s_q <= '0;
      val_a_q <= '0; val_b_q <= '0; val_c_q <= '0; val_s_q <= '0;
      bisect_q <= 1'b1;
      force_bis_q <= 1'b0;
      neg_q <= 1'b0;
      iter_q <= '0;
      den_q <= '0; prod_q <= '0; part_q <= '0; part_hi_q <= '0;
      numer_q <= '0; acc_q <= '0; s_q <= '0;
      res_valid_q <= 1'b0;
      kind_q <= KindEval; point_q <= '0; iters_q <= '0;
    end else begin
      res_valid_q <= 1'b0;
      case (cmd_i.op)
        OP_START: begin
          pt_a_q <= bracket_low_i;
          pt_b_q <= bracket_high_i;
          iter_q <= '0;
          bisect_q <= 1'b1;
          res_valid_q <= 1'b1;
          kind_q <= KindEval; point_q <= bracket_low_i; iters_q <= '0;
        end
        OP_LOAD_FA: begin
          val_a_q <= func_value_i;
          res_valid_q <= 1'b1;
          kind_q <= KindEval; point_q <= pt_b_q; iters_q <= '0;
        end
        OP_LOAD_FB: begin
          res_valid_q <= 1'b1;
          iters_q <= '0;
          if (!bkt_fb) begin
            val_b_q <= func_value_i;
            kind_q <= KindNoBkt; point_q <= '0;
          end else begin
            if (swap_fb) begin
              pt_a_q <= pt_b_q; val_a_q <= func_value_i;
              pt_b_q <= pt_a_q; val_b_q <= val_a_q;
              pt_c_q <= pt_b_q; point_q <= pt_b_q;
            end else begin
              val_b_q <= func_value_i;
              pt_c_q <= pt_a_q; point_q <= pt_a_q;
            end
            pt_d_q <= '0;
            bisect_q <= 1'b1;
            iter_q <= '0;
            kind_q <= KindEval;
          end
        end
        OP_LOAD_FC: val_c_q <= func_value_i;
        OP_PLAN: begin
          force_bis_q <= !use_iqi && !use_sec;
          acc_q <= '0;
        end
        OP_MUL_DEN: begin
          den_q <= mul_p;
          neg_q <= t_neg;
        end
        OP_MUL_FF:  prod_q <= mul_p;
        OP_MUL_XLO: part_q <= mul_p;
        OP_MUL_XHI: part_hi_q <= mul_p;
        OP_NUM_SUM: numer_q <= {part_hi_q, 32'd0} + {32'd0, part_q};
        OP_MUL_SEC: begin
          numer_q <= {32'd0, mul_p};
          den_q <= {32'd0, mag33(sec_df)};
          neg_q <= val_b_q[31] ^ sec_dx[32] ^ sec_df[32];
        end
        OP_ACC:     acc_q <= acc_q + sq_ext;
        OP_ACC_SEC: acc_q <= $signed({{11{pt_b_q[31]}}, pt_b_q}) - sq_ext;
        OP_CLAMP:   s_q <= clamp_s;
        OP_CHOOSE: begin
          pt_s_q <= s_new;
          bisect_q <= bis;
          res_valid_q <= 1'b1;
          kind_q <= KindEval; point_q <= s_new; iters_q <= iter_q;
        end
        OP_LOAD_FS: begin
          val_s_q <= func_value_i;
          pt_d_q <= pt_c_q;
          pt_c_q <= pt_b_q;
          if (swap_fs) begin
            pt_a_q <= nb; val_a_q <= nvb; pt_b_q <= na; val_b_q <= nva;
          end else begin
            pt_a_q <= na; val_a_q <= nva; pt_b_q <= nb; val_b_q <= nvb;
          end
          iter_q <= iter_q + 8'd1;
        end
        OP_FINISH: begin
          res_valid_q <= 1'b1;
          iters_q <= iter_q;
          if (cont) begin
            kind_q <= KindEval; point_q <= pt_c_q;
          end else begin
            kind_q <= KindRoot; point_q <= (mb < ms) ? pt_b_q : pt_s_q;
          end
        end
        default: ;
      endcase
    end
  end

  // Status back to the controller.
  assign status_o.bracketed = bkt_fb;
  assign status_o.use_iqi   = use_iqi;
  assign status_o.use_sec   = use_sec;
  assign status_o.div_done  = div_done;
  assign status_o.cont      = cont;

  assign result_valid_o = res_valid_q;
  assign kind_o         = kind_q;
  assign point_o        = point_q;
  assign iterations_o   = iters_q;

endmodule

// ----- src/brf_ctrl.sv -----
// Controller state machine of the Brent root finder.
module brf_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic                cmd_i,
  output logic                busy_o,
  input  brf_pkg::dp_status_t status_i,
  output brf_pkg::dp_cmd_t    cmd_o
);
  import brf_pkg::*;

  typedef enum logic [17:0] {
    ST_IDLE    = 18'h00001,
    ST_WAIT_FA = 18'h00002,
    ST_WAIT_FB = 18'h00004,
    ST_WAIT_FC = 18'h00008,
    ST_WAIT_FS = 18'h00010,
    ST_PLAN    = 18'h00020,
    ST_DEN     = 18'h00040,
    ST_FF      = 18'h00080,
    ST_XLO     = 18'h00100,
    ST_XHI     = 18'h00200,
    ST_NSUM    = 18'h00400,
    ST_SEC     = 18'h00800,
    ST_DGO     = 18'h01000,
    ST_DWAIT   = 18'h02000,
    ST_ACC     = 18'h04000,
    ST_CLAMP   = 18'h08000,
    ST_CHOOSE  = 18'h10000,
    ST_FINISH  = 18'h20000
  } state_e;

  state_e     state_q, state_d;
  logic [1:0] term_q, term_d;
  logic       sec_q, sec_d;
  logic       ready;

  // The block takes a beat only while it waits for one.
  assign ready = (state_q == ST_IDLE) || (state_q == ST_WAIT_FA) ||
                 (state_q == ST_WAIT_FB) || (state_q == ST_WAIT_FC) ||
                 (state_q == ST_WAIT_FS);
  assign busy_o = !ready;

  // Next state and datapath operation.
  always_comb begin
    state_d    = state_q;
    term_d     = term_q;
    sec_d      = sec_q;
    cmd_o.op   = OP_NONE;
    cmd_o.term = term_q;
    if (ready && start_i && (cmd_i == CmdStart)) begin
      // A start beat aborts any search.
      cmd_o.op = OP_START;
      state_d  = ST_WAIT_FA;
    end else begin
      unique case (state_q)
        ST_IDLE: ;
        ST_WAIT_FA: begin
          if (start_i) begin
            cmd_o.op = OP_LOAD_FA;
            state_d  = ST_WAIT_FB;
          end
        end
        ST_WAIT_FB: begin
          if (start_i) begin
            cmd_o.op = OP_LOAD_FB;
            state_d  = status_i.bracketed ? ST_WAIT_FC : ST_IDLE;
          end
        end
        ST_WAIT_FC: begin
          if (start_i) begin
            cmd_o.op = OP_LOAD_FC;
            state_d  = ST_PLAN;
          end
        end
        ST_WAIT_FS: begin
          if (start_i) begin
            cmd_o.op = OP_LOAD_FS;
            state_d  = ST_FINISH;
          end
        end
        ST_PLAN: begin
          cmd_o.op = OP_PLAN;
          term_d   = '0;
          sec_d    = !status_i.use_iqi;
          if (status_i.use_iqi) begin
            state_d = ST_DEN;
          end else if (status_i.use_sec) begin
            state_d = ST_SEC;
          end else begin
            state_d = ST_CLAMP;
          end
        end
        ST_DEN: begin
          cmd_o.op = OP_MUL_DEN;
          state_d  = ST_FF;
        end
        ST_FF: begin
          cmd_o.op = OP_MUL_FF;
          state_d  = ST_XLO;
        end
        ST_XLO: begin
          cmd_o.op = OP_MUL_XLO;
          state_d  = ST_XHI;
        end
        ST_XHI: begin
          cmd_o.op = OP_MUL_XHI;
          state_d  = ST_NSUM;
        end
        ST_NSUM: begin
          cmd_o.op = OP_NUM_SUM;
          state_d  = ST_DGO;
        end
        ST_SEC: begin
          cmd_o.op = OP_MUL_SEC;
          state_d  = ST_DGO;
        end
        ST_DGO: begin
          cmd_o.op = OP_DIV_GO;
          state_d  = ST_DWAIT;
        end
        ST_DWAIT: begin
          if (status_i.div_done) begin
            state_d = ST_ACC;
          end
        end
        ST_ACC: begin
          cmd_o.op = sec_q ? OP_ACC_SEC : OP_ACC;
          if (sec_q || (term_q == LastTerm)) begin
            state_d = ST_CLAMP;
          end else begin
            term_d  = term_q + 2'd1;
            state_d = ST_DEN;
          end
        end
        ST_CLAMP: begin
          cmd_o.op = OP_CLAMP;
          state_d  = ST_CHOOSE;
        end
        ST_CHOOSE: begin
          cmd_o.op = OP_CHOOSE;
          state_d  = ST_WAIT_FS;
        end
        ST_FINISH: begin
          cmd_o.op = OP_FINISH;
          state_d  = status_i.cont ? ST_WAIT_FC : ST_IDLE;
        end
        default: state_d = ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      term_q  <= '0;
      sec_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      term_q  <= term_d;
      sec_q   <= sec_d;
    end
  end

endmodule

// ----- src/brent_root_finder.sv -----
// Result beats: a start beat and the responses for a and b give their result beat
// in the cycle after acceptance, the s response after the finish state; the response
// for c runs three divisions on the one shared divider with inverse quadratic
// interpolation, one with the secant step and none with bisection.
// One beat at a time: busy_o is high while a step is being worked out.
// Reset: asynchronous, active low; clears the controller and all registers.
module brent_root_finder #(
  parameter int unsigned FracBits = brf_pkg::FracBits
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  output logic                         busy_o,
  input  logic                         cmd_i,
  input  logic signed [31:0]           bracket_low_i,
  input  logic signed [31:0]           bracket_high_i,
  input  logic signed [31:0]           func_value_i,
  input  logic                         cfg_we_i,
  input  logic [brf_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [brf_pkg::TolW-1:0]     cfg_data_i,
  output logic                         result_valid_o,
  output logic [brf_pkg::KindW-1:0]    kind_o,
  output logic signed [31:0]           point_o,
  output logic [brf_pkg::IterW-1:0]    iterations_o
);
  import brf_pkg::*;

  dp_cmd_t    dp_cmd;
  dp_status_t dp_status;

  // Controller.
  brf_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .cmd_i    (cmd_i),
    .busy_o   (busy_o),
    .status_i (dp_status),
    .cmd_o    (dp_cmd)
  );

  // Datapath.
  brf_datapath #(
    .FracBits (FracBits)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (dp_cmd),
    .status_o       (dp_status),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .bracket_low_i  (bracket_low_i),
    .bracket_high_i (bracket_high_i),
    .func_value_i   (func_value_i),
    .result_valid_o (result_valid_o),
    .kind_o         (kind_o),
    .point_o        (point_o),
    .iterations_o   (iterations_o)
  );

  // A start beat is answered at once by a request to evaluate the first end.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && (cmd_i == CmdStart)) |=>
      (result_valid_o && (kind_o == KindEval) && (iterations_o == '0)))
    else $error("start beat not answered by an evaluate request");

  // Leaving a computation always delivers a result beat.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy_o) |-> result_valid_o)
    else $error("computation ended without a result beat");

  // The not-bracketed error carries zero point and zero iterations.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && (kind_o == KindNoBkt)) |-> ((point_o == '0) && (iterations_o == '0)))
    else $error("bracket error with non-zero payload");

endmodule
